@@ rtl/sria_pkg.sv @@
// Shared types, constants and the term table of the stick-rate attitude integrator.
// No dependencies; every other file of the block uses this package.
package sria_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int QUAT_FRAC_BITS = 30;

    localparam int RATE_W  = 17;
    localparam int QUAT_W  = 32;
    localparam int IN_W    = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W   = ((3 * RATE_W + 4 * QUAT_W + 7) / 8) * 8;
    localparam int DIV_W   = 31;
    localparam int MUL_W   = 33;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 3;

    localparam logic [DIV_W-1:0] Q_ONE      = DIV_W'(1) << QUAT_FRAC_BITS;
    localparam logic [25:0]      HALF_PI_Q32 = 26'd37480660;   // pi/360 in Q0.32

    localparam logic [3:0] TERM_LAST  = 4'd12;   // 12 quaternion product terms
    localparam logic [3:0] SUMSQ_LAST = 4'd4;
    localparam logic [4:0] SQRT_FIRST = 5'd31;   // 32 root digits
    localparam logic [4:0] SHAPE_FRAC = 5'd16;
    localparam logic [4:0] NORM_FRAC  = 5'(QUAT_FRAC_BITS);

    typedef enum logic [CIDX_W-1:0] {
        REG_STICK_MIN  = 3'd0,
        REG_STICK_MAX  = 3'd1,
        REG_STICK_CTR  = 3'd2,
        REG_DEADZONE   = 3'd3,
        REG_RATE_LIMIT = 3'd4,
        REG_STEP_TIME  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] minimum;
        logic [SAMPLE_BITS-1:0] maximum;
        logic [SAMPLE_BITS-1:0] center;
        logic [15:0]            deadzone;
        logic [9:0]             rate_limit;
        logic [23:0]            step_time;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SPAN,
        OP_DZ,
        OP_SQ,
        OP_SCALE,
        OP_RATE,
        OP_HA1,
        OP_HA2,
        OP_HA3,
        OP_HA4,
        OP_QTERM,
        OP_MAG,
        OP_SUMSQ,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_NDIV,
        OP_NSTORE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic [3:0] term;
        logic [4:0] k;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } stat_t;

    // one product term of q (x) (0, h): attitude index, half-angle index
    // (0 pitch, 1 roll, 2 yaw), subtract flag, last term of its component
    typedef struct packed {
        logic [1:0] qi;
        logic [1:0] hi;
        logic       neg;
        logic       last;
        logic [1:0] comp;
    } term_t;

    function automatic term_t term_info(input logic [3:0] t);
        term_t r;
        r = '{qi: 2'd0, hi: 2'd0, neg: 1'b0, last: 1'b0, comp: 2'd0};
        case (t)
            4'd0:  r = '{qi: 2'd1, hi: 2'd1, neg: 1'b1, last: 1'b0, comp: 2'd0};
            4'd1:  r = '{qi: 2'd2, hi: 2'd0, neg: 1'b1, last: 1'b0, comp: 2'd0};
            4'd2:  r = '{qi: 2'd3, hi: 2'd2, neg: 1'b1, last: 1'b1, comp: 2'd0};
            4'd3:  r = '{qi: 2'd0, hi: 2'd1, neg: 1'b0, last: 1'b0, comp: 2'd1};
            4'd4:  r = '{qi: 2'd2, hi: 2'd2, neg: 1'b0, last: 1'b0, comp: 2'd1};
            4'd5:  r = '{qi: 2'd3, hi: 2'd0, neg: 1'b1, last: 1'b1, comp: 2'd1};
            4'd6:  r = '{qi: 2'd0, hi: 2'd0, neg: 1'b0, last: 1'b0, comp: 2'd2};
            4'd7:  r = '{qi: 2'd1, hi: 2'd2, neg: 1'b1, last: 1'b0, comp: 2'd2};
            4'd8:  r = '{qi: 2'd3, hi: 2'd1, neg: 1'b0, last: 1'b1, comp: 2'd2};
            4'd9:  r = '{qi: 2'd0, hi: 2'd2, neg: 1'b0, last: 1'b0, comp: 2'd3};
            4'd10: r = '{qi: 2'd1, hi: 2'd0, neg: 1'b0, last: 1'b0, comp: 2'd3};
            4'd11: r = '{qi: 2'd2, hi: 2'd1, neg: 1'b1, last: 1'b1, comp: 2'd3};
            default: r = '{qi: 2'd0, hi: 2'd0, neg: 1'b0, last: 1'b0, comp: 2'd0};
        endcase
        return r;
    endfunction

endpackage

@@ rtl/stick_rate_attitude_integrator.sv @@
// Stick-rate attitude integrator, top level: configuration registers, sequencer, datapath.
// Depends on sria_pkg, sria_ctrl, sria_dp (and sria_div below it).
//
// One input word carries three raw stick samples; each is normalized against
// the stick center and end, passed through the deadzone rescale, squared and
// scaled to a rate in 1/64 deg/s. The rates drive one step of quaternion
// integration, q := normalize(q + q (x) (0, roll, pitch, yaw) * dt / 2), with
// the attitude starting at identity after reset. One output word per input
// word carries the three rates and the new attitude in Q1.30. Each item is
// accepted, then each stick takes two divisions to 16 fraction bits and 7 further
// steps of multiplying and storing, followed by the 12 quaternion product terms and
// a final accumulate, the magnitudes and sum of squares, 32 root steps, four
// divisions to 30 fraction bits for the normalization and the load of the output
// register. A division whose quotient saturates or whose divisor is zero ends at
// once, so some items finish sooner; a stalled output adds its wait. One item is in
// flight at a time. The finished word sits in an output register, so the next
// input word is taken while the last result waits.
// A zero norm leaves the attitude at all zeros from then on. Configuration
// writes are always ready; write only while no item is in flight.
module stick_rate_attitude_integrator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [11:0] pitch_sample, [23:12] roll_sample, [35:24] yaw_sample
    input  logic [sria_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [16:0] pitch_rate_out, [33:17] roll_rate_out, [50:34] yaw_rate_out,
    // [82:51] quat_scalar, [114:83] quat_x, [146:115] quat_y, [178:147] quat_z
    output logic [sria_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sria_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [sria_pkg::CFG_W-1:0]   cfg_data
);
    import sria_pkg::*;

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    // config write port, never stalls; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minimum    <= SAMPLE_BITS'(400);
            cfg_reg.maximum    <= SAMPLE_BITS'(3600);
            cfg_reg.center     <= SAMPLE_BITS'(1900);
            cfg_reg.deadzone   <= 16'd3277;     // 0.05 in Q0.16
            cfg_reg.rate_limit <= 10'd360;
            cfg_reg.step_time  <= 24'd83886;    // 1/200 s in Q0.24
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_STICK_MIN:  cfg_reg.minimum    <= cfg_data[SAMPLE_BITS-1:0];
                REG_STICK_MAX:  cfg_reg.maximum    <= cfg_data[SAMPLE_BITS-1:0];
                REG_STICK_CTR:  cfg_reg.center     <= cfg_data[SAMPLE_BITS-1:0];
                REG_DEADZONE:   cfg_reg.deadzone   <= cfg_data[15:0];
                REG_RATE_LIMIT: cfg_reg.rate_limit <= cfg_data[9:0];
                REG_STEP_TIME:  cfg_reg.step_time  <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    sria_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sria_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

endmodule

@@ rtl/sria_div.sv @@
// Iterative restoring divider: quot = (num << frac) / den, one bit per cycle.
// Saturates to 1 << frac when num >= den, gives 0 for a zero divisor. Uses sria_pkg.
module sria_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sria_pkg::DIV_W-1:0] num,
    input  logic [sria_pkg::DIV_W-1:0] den,
    input  logic [4:0]                 frac,
    output logic [sria_pkg::DIV_W-1:0] quot,
    output logic                       busy
);
    import sria_pkg::*;

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DIV_W:0]   rem2;
    logic [DIV_W:0]   diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem2      = {rem_reg, 1'b0};
        diff      = rem2 - {1'b0, den_reg};
        if (start)
        begin
            den_next = den;
            if (den == '0)
            begin
                quot_next = '0;
                busy_next = 1'b0;
            end
            else if (num >= den)
            begin
                quot_next = DIV_W'(1) << frac;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = num;
                quot_next = '0;
                cnt_next  = frac;
                busy_next = (frac != 5'd0);
            end
        end
        else if (busy_reg)
        begin
            if (rem2 >= {1'b0, den_reg})
            begin
                rem_next  = diff[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem2[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 5'd1;
            busy_next = (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign quot = quot_reg;
    assign busy = busy_reg;

endmodule

@@ rtl/sria_dp.sv @@
// Datapath: stick shaping, half-angle, quaternion product, norm and root.
// One shared 33x33 multiplier, one sria_div instance. Depends on sria_pkg, sria_div.
module sria_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sria_pkg::cfg_t             cfg,
    input  sria_pkg::cmd_t             cmd,
    output sria_pkg::stat_t            stat,
    input  logic [sria_pkg::IN_W-1:0]  in_data,
    output logic [sria_pkg::OUT_W-1:0] out_data
);
    import sria_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0]        samp_reg [3];
    logic                 pos_reg;
    logic signed [17:0]   rate_reg [3];
    logic signed [31:0]   half_reg [3];
    logic signed [31:0]   q_reg [4];
    logic signed [33:0]   n_reg [4];
    logic [29:0]          m_reg [4];
    logic signed [63:0]   acc_reg;
    logic signed [65:0]   prod_reg;
    logic [15:0]          lo_reg;
    logic [50:0]          hik_reg;
    logic [63:0]          sum_reg;
    logic [63:0]          sqv_reg;
    logic [63:0]          sqr_reg;
    logic [OUT_W-1:0]     out_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    div_start;
    logic [DIV_W-1:0]        div_n, div_d, div_q;
    logic [4:0]              div_f;
    logic                    div_busy;

    // shaping
    logic [SB-1:0]  x_s, num_s, den_hi, den_lo, den_s;
    logic           pos_s;
    logic [16:0]    a_s, dz_s, dz_num, dz_den;
    logic [16:0]    r_s;
    logic signed [17:0] rate_s, rr;
    logic [17:0]    rmag;
    // half angle
    logic [51:0]    hsum;
    logic [35:0]    h36, hsh;
    logic [DIV_W-1:0] hsat;
    // quaternion terms
    term_t              cur, prv;
    logic signed [63:0] pterm, acc_sum, acc_shift;
    logic signed [31:0] qb;
    logic signed [33:0] n_new;
    // magnitudes
    logic [33:0]    nabs [4];
    logic [33:0]    mx;
    logic [2:0]     sh;
    // root
    logic [63:0]    sq_bit, sq_trial;
    logic signed [31:0] nq;

    sria_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .frac  (div_f),
        .quot  (div_q),
        .busy  (div_busy)
    );

    assign stat.div_busy = div_busy;

    always_comb
    begin
        // deflection against center and the stick end on that side
        x_s    = samp_reg[cmd.idx];
        pos_s  = x_s > cfg.center;
        num_s  = pos_s ? x_s - cfg.center : cfg.center - x_s;
        den_hi = (cfg.maximum > cfg.center) ? cfg.maximum - cfg.center
                                            : cfg.center - cfg.maximum;
        den_lo = (cfg.center > cfg.minimum) ? cfg.center - cfg.minimum
                                            : cfg.minimum - cfg.center;
        den_s  = pos_s ? den_hi : den_lo;

        // deadzone rescale operands
        a_s    = div_q[16:0];
        dz_s   = {1'b0, cfg.deadzone};
        dz_num = (a_s < dz_s) ? 17'd0 : a_s - dz_s;
        dz_den = 17'h10000 - dz_s;

        r_s    = prod_reg[26:10];
        rate_s = pos_reg ? $signed({1'b0, r_s}) : -$signed({1'b0, r_s});
        rr     = rate_reg[cmd.idx];
        rmag   = rr[17] ? 18'(-rr) : 18'(rr);

        hsum = {1'b0, hik_reg} + {26'd0, prod_reg[41:16]};
        h36  = hsum[51:16];
        hsh  = h36 >> (30 - QUAT_FRAC_BITS);
        hsat = (hsh > 36'(Q_ONE)) ? Q_ONE : hsh[DIV_W-1:0];

        cur       = term_info(cmd.term);
        prv       = term_info(cmd.term - 4'd1);
        pterm     = $signed(prod_reg[63:0]);
        acc_sum   = prv.neg ? acc_reg - pterm : acc_reg + pterm;
        acc_shift = acc_sum >>> QUAT_FRAC_BITS;
        qb        = q_reg[prv.comp];
        n_new     = 34'(acc_shift) + {{2{qb[31]}}, qb};

        mx = '0;
        for (int i = 0; i < 4; i++)
        begin
            nabs[i] = n_reg[i][33] ? 34'(-n_reg[i]) : 34'(n_reg[i]);
            if (nabs[i] > mx)
                mx = nabs[i];
        end
        // shift that brings the largest magnitude below 2^30
        if (mx[33])
            sh = 3'd4;
        else if (mx[32])
            sh = 3'd3;
        else if (mx[31])
            sh = 3'd2;
        else if (mx[30])
            sh = 3'd1;
        else
            sh = 3'd0;

        sq_bit   = 64'd1 << {cmd.k, 1'b0};
        sq_trial = sqr_reg + sq_bit;

        nq = n_reg[cmd.idx][33] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        div_f     = '0;
        case (cmd.op)
            OP_SPAN:
            begin
                div_start = 1'b1;
                div_n     = DIV_W'(num_s);
                div_d     = DIV_W'(den_s);
                div_f     = SHAPE_FRAC;
            end
            OP_DZ:
            begin
                div_start = 1'b1;
                div_n     = DIV_W'(dz_num);
                div_d     = DIV_W'(dz_den);
                div_f     = SHAPE_FRAC;
            end
            OP_SQ:
            begin
                mul_a = {16'd0, div_q[16:0]};
                mul_b = {16'd0, div_q[16:0]};
            end
            OP_SCALE:
            begin
                mul_a = {16'd0, prod_reg[32:16]};
                mul_b = {23'd0, cfg.rate_limit};
            end
            OP_HA1:
            begin
                mul_a = {16'd0, rmag[16:0]};
                mul_b = {9'd0, cfg.step_time};
            end
            OP_HA2:
            begin
                mul_a = {8'd0, prod_reg[40:16]};
                mul_b = {7'd0, HALF_PI_Q32};
            end
            OP_HA3:
            begin
                mul_a = {17'd0, lo_reg};
                mul_b = {7'd0, HALF_PI_Q32};
            end
            OP_QTERM:
            begin
                if (cmd.term != TERM_LAST)
                begin
                    mul_a = {q_reg[cur.qi][31], q_reg[cur.qi]};
                    mul_b = {half_reg[cur.hi][31], half_reg[cur.hi]};
                end
            end
            OP_SUMSQ:
            begin
                if (cmd.term != SUMSQ_LAST)
                begin
                    mul_a = {3'd0, m_reg[cmd.term[1:0]]};
                    mul_b = {3'd0, m_reg[cmd.term[1:0]]};
                end
            end
            OP_NDIV:
            begin
                div_start = 1'b1;
                div_n     = {1'b0, m_reg[cmd.idx]};
                div_d     = sqr_reg[DIV_W-1:0];
                div_f     = NORM_FRAC;
            end
            default:
            begin
            end
        endcase
    end

    // attitude state: identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[0] <= $signed({1'b0, Q_ONE});
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
        end
        else if (cmd.op == OP_NSTORE)
        begin
            q_reg[cmd.idx] <= nq;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
            begin
                samp_reg[0] <= in_data[SB-1:0];
                samp_reg[1] <= in_data[2*SB-1:SB];
                samp_reg[2] <= in_data[3*SB-1:2*SB];
                acc_reg     <= '0;
            end
            OP_SPAN:
                pos_reg <= pos_s;
            OP_RATE:
                rate_reg[cmd.idx] <= rate_s;
            OP_HA2:
                lo_reg <= prod_reg[15:0];
            OP_HA3:
                hik_reg <= prod_reg[50:0];
            OP_HA4:
                half_reg[cmd.idx] <= rr[17] ? -$signed({1'b0, hsat}) : $signed({1'b0, hsat});
            OP_QTERM:
            begin
                if (cmd.term != 4'd0)
                begin
                    if (prv.last)
                    begin
                        n_reg[prv.comp] <= n_new;
                        acc_reg         <= '0;
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                    end
                end
            end
            OP_MAG:
            begin
                for (int i = 0; i < 4; i++)
                    m_reg[i] <= 30'(nabs[i] >> sh);
                sum_reg <= '0;
            end
            OP_SUMSQ:
            begin
                if (cmd.term != 4'd0)
                    sum_reg <= sum_reg + prod_reg[63:0];
            end
            OP_SQRT_INIT:
            begin
                sqv_reg <= sum_reg;
                sqr_reg <= '0;
            end
            OP_SQRT:
            begin
                if (sqv_reg >= sq_trial)
                begin
                    sqv_reg <= sqv_reg - sq_trial;
                    sqr_reg <= (sqr_reg >> 1) + sq_bit;
                end
                else
                begin
                    sqr_reg <= sqr_reg >> 1;
                end
            end
            OP_OUT:
                out_reg <= OUT_W'({q_reg[3], q_reg[2], q_reg[1], q_reg[0],
                                   rate_reg[2][RATE_W-1:0], rate_reg[1][RATE_W-1:0],
                                   rate_reg[0][RATE_W-1:0]});
            default:
            begin
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

@@ rtl/sria_ctrl.sv @@
// Sequencer of the integrator: walks the datapath through one item and
// owns the stream handshakes. Depends on sria_pkg.
module sria_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  sria_pkg::stat_t stat,
    output sria_pkg::cmd_t  cmd
);
    import sria_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_SPAN      = 20'h00002,
        S_SPAN_W    = 20'h00004,
        S_DZ        = 20'h00008,
        S_DZ_W      = 20'h00010,
        S_SQ        = 20'h00020,
        S_SCALE     = 20'h00040,
        S_RATE      = 20'h00080,
        S_HA1       = 20'h00100,
        S_HA2       = 20'h00200,
        S_HA3       = 20'h00400,
        S_HA4       = 20'h00800,
        S_QTERM     = 20'h01000,
        S_MAG       = 20'h02000,
        S_SUMSQ     = 20'h04000,
        S_SQRT_INIT = 20'h08000,
        S_SQRT      = 20'h10000,
        S_NDIV      = 20'h20000,
        S_NDIV_W    = 20'h40000,
        S_OUT       = 20'h80000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ax_reg, ax_next;
    logic [3:0] t_reg, t_next;
    logic [4:0] k_reg, k_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        ov_next    = ov_reg;
        in_ready   = 1'b0;
        cmd        = '{op: OP_NOP, idx: ax_reg, term: t_reg, k: k_reg};
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    ax_next    = 2'd0;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                cmd.op     = OP_SPAN;
                state_next = S_SPAN_W;
            end
            S_SPAN_W:
                if (!stat.div_busy)
                    state_next = S_DZ;
            S_DZ:
            begin
                cmd.op     = OP_DZ;
                state_next = S_DZ_W;
            end
            S_DZ_W:
                if (!stat.div_busy)
                    state_next = S_SQ;
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_RATE;
            end
            S_RATE:
            begin
                cmd.op     = OP_RATE;
                state_next = S_HA1;
            end
            S_HA1:
            begin
                cmd.op     = OP_HA1;
                state_next = S_HA2;
            end
            S_HA2:
            begin
                cmd.op     = OP_HA2;
                state_next = S_HA3;
            end
            S_HA3:
            begin
                cmd.op     = OP_HA3;
                state_next = S_HA4;
            end
            S_HA4:
            begin
                cmd.op = OP_HA4;
                if (ax_reg == 2'd2)
                begin
                    ax_next    = 2'd0;
                    t_next     = 4'd0;
                    state_next = S_QTERM;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_SPAN;
                end
            end
            S_QTERM:
            begin
                cmd.op = OP_QTERM;
                if (t_reg == TERM_LAST)
                    state_next = S_MAG;
                else
                    t_next = t_reg + 4'd1;
            end
            S_MAG:
            begin
                cmd.op     = OP_MAG;
                t_next     = 4'd0;
                state_next = S_SUMSQ;
            end
            S_SUMSQ:
            begin
                cmd.op = OP_SUMSQ;
                if (t_reg == SUMSQ_LAST)
                    state_next = S_SQRT_INIT;
                else
                    t_next = t_reg + 4'd1;
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                k_next     = SQRT_FIRST;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (k_reg == 5'd0)
                begin
                    ax_next    = 2'd0;
                    state_next = S_NDIV;
                end
                else
                begin
                    k_next = k_reg - 5'd1;
                end
            end
            S_NDIV:
            begin
                cmd.op     = OP_NDIV;
                state_next = S_NDIV_W;
            end
            S_NDIV_W:
            begin
                if (!stat.div_busy)
                begin
                    cmd.op = OP_NSTORE;
                    if (ax_reg == 2'd3)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 2'd1;
                        state_next = S_NDIV;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.op     = OP_OUT;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
            t_reg     <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            t_reg     <= t_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

@@ rtl/sria_checker.sv @@
// Port-level checks of the stick-rate attitude integrator, bound to the top level.
// Depends on sria_pkg and stick_rate_attitude_integrator.
module sria_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [sria_pkg::OUT_W-1:0] m_axis_tdata
);

    // one item in flight: an accepted word closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item was in flight");

    // a fresh result means the sequencer is back to idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown while the sequencer is still busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // normalized scalar part never exceeds one in magnitude
    a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[82:51]) <= 32'sd1073741824) &&
                          ($signed(m_axis_tdata[82:51]) >= -32'sd1073741824))
        else $error("quaternion scalar out of range");

endmodule

bind stick_rate_attitude_integrator sria_checker u_sria_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb.sv @@
// Testbench for stick_rate_attitude_integrator: directed and random stick words,
// scored against an in-bench model of shaping and quaternion integration.
// Depends on sria_pkg and the block's RTL.
module tb;
    import sria_pkg::*;

    localparam int ITEM_LAT  = 400;
    localparam int WDOG_MAX  = 20000;

    // pitch rate in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic signed [31:0] qz;
        logic signed [31:0] qy;
        logic signed [31:0] qx;
        logic signed [31:0] qs;
        logic signed [16:0] yaw_out;
        logic signed [16:0] roll_out;
        logic signed [16:0] pitch_out;
    } attitude_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    // model copy of configuration and attitude
    logic [11:0] m_min, m_max, m_ctr;
    logic [15:0] m_dz;
    logic [9:0]  m_rlim;
    logic [23:0] m_dt;
    longint      att [4];

    attitude_word_t expected_words [$];
    int  fail_count = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  idle_cycles = 0;
    bit  burst_mode = 1'b1;    // sender bursts vs. steady
    bit  rx_stall_on = 1'b1;

    stick_rate_attitude_integrator DUT (.*);

    always #5 clk = ~clk;

    // ---------------- model ----------------
    function automatic longint floor_shr(longint v, int n);
        longint u;
        if (v >= 0)
            return v >>> n;
        u = -v;
        return -((u + ((64'sd1 << n) - 1)) >>> n);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
                r >>= 1;
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic int stick_rate(logic [11:0] x);
        longint unsigned num, den, a, b, s, r;
        bit pos;
        pos = x > m_ctr;
        num = pos ? x - m_ctr : m_ctr - x;
        if (pos)
            den = m_max > m_ctr ? m_max - m_ctr : m_ctr - m_max;
        else
            den = m_ctr > m_min ? m_ctr - m_min : m_min - m_ctr;
        a = den != 0 ? (num << 16) / den : 0;
        if (a > 65536)
            a = 65536;
        if (a < m_dz)
            b = 0;
        else
            b = ((a - m_dz) << 16) / (65536 - m_dz);
        s = (b * b) >> 16;
        r = (s * m_rlim) >> 10;
        return pos ? int'(r) : -int'(r);
    endfunction

    function automatic longint half_angle(int rate);
        longint unsigned p, hi, lo, h;
        p = longint'(rate < 0 ? -rate : rate) * m_dt;
        hi = p >> 16;
        lo = p & 64'hFFFF;
        h = (hi * 37480660 + ((lo * 37480660) >> 16)) >> 16;
        h >>= (30 - QUAT_FRAC_BITS);
        if (h > (64'd1 << QUAT_FRAC_BITS))
            h = 64'd1 << QUAT_FRAC_BITS;
        return rate < 0 ? -longint'(h) : longint'(h);
    endfunction

    function automatic attitude_word_t integrate_step(logic [11:0] ps, logic [11:0] rs,
                                                      logic [11:0] ys);
        attitude_word_t w;
        int pr, rr, yr, sh;
        longint a, b, c, n [4];
        longint unsigned m [4], mx, sum, nrm, v;
        pr = stick_rate(ps);
        rr = stick_rate(rs);
        yr = stick_rate(ys);
        a = half_angle(rr);
        b = half_angle(pr);
        c = half_angle(yr);
        n[0] = att[0] + floor_shr(-(att[1]*a) - att[2]*b - att[3]*c, QUAT_FRAC_BITS);
        n[1] = att[1] + floor_shr(att[0]*a + att[2]*c - att[3]*b, QUAT_FRAC_BITS);
        n[2] = att[2] + floor_shr(att[0]*b - att[1]*c + att[3]*a, QUAT_FRAC_BITS);
        n[3] = att[3] + floor_shr(att[0]*c + att[1]*b - att[2]*a, QUAT_FRAC_BITS);
        mx = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = n[i] < 0 ? -n[i] : n[i];
            if (m[i] > mx)
                mx = m[i];
        end
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30))
            sh++;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] >>= sh;
            sum += m[i] * m[i];
        end
        nrm = int_sqrt(sum);
        for (int i = 0; i < 4; i++)
        begin
            v = nrm != 0 ? (m[i] << QUAT_FRAC_BITS) / nrm : 0;
            att[i] = longint'(int'(n[i] < 0 ? -int'(v) : int'(v)));
        end
        w.pitch_out = 17'(pr);
        w.roll_out = 17'(rr);
        w.yaw_out = 17'(yr);
        w.qs = 32'(att[0]);
        w.qx = 32'(att[1]);
        w.qy = 32'(att[2]);
        w.qz = 32'(att[3]);
        return w;
    endfunction

    // ---------------- drivers ----------------
    task automatic write_reg(reg_idx_t idx, logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_STICK_MIN:  m_min  = value[11:0];
            REG_STICK_MAX:  m_max  = value[11:0];
            REG_STICK_CTR:  m_ctr  = value[11:0];
            REG_DEADZONE:   m_dz   = value[15:0];
            REG_RATE_LIMIT: m_rlim = value[9:0];
            REG_STEP_TIME:  m_dt   = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid first so the last word is not taken again
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (ITEM_LAT) @(posedge clk);
    endtask

    task automatic set_config(logic [11:0] mn, logic [11:0] mxv, logic [11:0] ct,
                              logic [15:0] dz, logic [9:0] rl, logic [23:0] dt);
        drain();
        write_reg(REG_STICK_MIN, mn);
        write_reg(REG_STICK_MAX, mxv);
        write_reg(REG_STICK_CTR, ct);
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_RATE_LIMIT, rl);
        write_reg(REG_STEP_TIME, dt);
    endtask

    // one stick word; valid stays high across back-to-back words
    task automatic send_sticks(logic [11:0] ps, logic [11:0] rs, logic [11:0] ys);
        int gap;
        gap = burst_mode ? (($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ys, rs, ps};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_words.push_back(integrate_step(ps, rs, ys));
        words_sent++;
    endtask

    task automatic idle_sender();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // ---------------- receiver ----------------
    always @(negedge clk)
        m_axis_tready <= rx_stall_on ? ($urandom_range(0, 9) > 3) : 1'b1;

    always @(posedge clk)
    begin
        attitude_word_t got, exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(attitude_word_t)-1:0];
            words_seen++;
            if (expected_words.size() == 0)
            begin
                $error("output word with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (got.pitch_out !== exp_w.pitch_out)
                    begin $error("pitch_rate_out exp %0d got %0d", exp_w.pitch_out,
                                 got.pitch_out); fail_count++; end
                if (got.roll_out !== exp_w.roll_out)
                    begin $error("roll_rate_out exp %0d got %0d", exp_w.roll_out,
                                 got.roll_out); fail_count++; end
                if (got.yaw_out !== exp_w.yaw_out)
                    begin $error("yaw_rate_out exp %0d got %0d", exp_w.yaw_out,
                                 got.yaw_out); fail_count++; end
                if (got.qs !== exp_w.qs)
                    begin $error("quat_scalar exp %0d got %0d", exp_w.qs, got.qs);
                          fail_count++; end
                if (got.qx !== exp_w.qx)
                    begin $error("quat_x exp %0d got %0d", exp_w.qx, got.qx);
                          fail_count++; end
                if (got.qy !== exp_w.qy)
                    begin $error("quat_y exp %0d got %0d", exp_w.qy, got.qy);
                          fail_count++; end
                if (got.qz !== exp_w.qz)
                    begin $error("quat_z exp %0d got %0d", exp_w.qz, got.qz);
                          fail_count++; end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_extremes();
        // reset settings: full/zero deflection, center, each axis alone
        send_sticks(12'd0, 12'd1900, 12'd1900);
        send_sticks(12'd4095, 12'd4095, 12'd4095);
        send_sticks(12'd1900, 12'd1900, 12'd1900);   // at center, negative side
        send_sticks(12'd1900, 12'd0, 12'd1900);
        send_sticks(12'd1900, 12'd1900, 12'd0);
        send_sticks(12'hAAA, 12'h555, 12'hFFF);
        send_sticks(12'd1990, 12'd1810, 12'd2100);   // near the deadzone, each outside it
    endtask

    task automatic test_odd_spans();
        // zero span on positive side, end on wrong side on negative side
        set_config(12'd3000, 12'd2000, 12'd2000, 16'd0, 10'd1023, 24'd83886);
        send_sticks(12'd2500, 12'd1000, 12'd4095);
        send_sticks(12'd0, 12'd2000, 12'd2001);
        // deadzone at extreme, rate limit zero and then at its maximum
        set_config(12'd0, 12'd4095, 12'd2048, 16'hFFFF, 10'd0, 24'd1);
        send_sticks(12'd0, 12'd4095, 12'd2047);
        set_config(12'd0, 12'd4095, 12'd2048, 16'hFFFF, 10'd1023, 24'd1000);
        send_sticks(12'd0, 12'd4095, 12'd2047);
        // huge increments: half angle saturates
        set_config(12'd0, 12'd4095, 12'd2048, 16'd0, 10'd1023, 24'hFFFFFF);
        send_sticks(12'd4095, 12'd0, 12'd4095);
        send_sticks(12'd0, 12'd4095, 12'd0);
        send_sticks(12'd4095, 12'd4095, 12'd0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
                set_config(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                           12'($urandom_range(0, 4095)),
                           16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 8000)),
                           10'($urandom_range(0, 1023)),
                           24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12)));
            if (i == 100)
            begin
                idle_sender();
                drain();   // pause until every result has come
            end
            burst_mode  = (i % 300) < 220;
            rx_stall_on = (i % 250) < 180;
            send_sticks(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                        12'($urandom_range(0, 4095)));
        end
        idle_sender();
    endtask

    initial
    begin
        m_min = 400; m_max = 3600; m_ctr = 1900;
        m_dz = 3277; m_rlim = 360; m_dt = 83886;
        att[0] = 64'sd1 << QUAT_FRAC_BITS; att[1] = 0; att[2] = 0; att[3] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_extremes();
        test_odd_spans();
        // back to the reset values before random traffic
        set_config(12'd400, 12'd3600, 12'd1900, 16'd3277, 10'd360, 24'd83886);
        test_random(800);
        drain();
        $display("covered %0d stick words (%0d results): extremes, odd spans,", words_sent,
                 words_seen);
        $display("saturating steps, random configs with bursty input and stalled output");
        if (fail_count == 0 && expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ stick_rate_attitude_integrator.f @@
rtl/sria_pkg.sv
rtl/sria_div.sv
rtl/sria_dp.sv
rtl/sria_ctrl.sv
rtl/stick_rate_attitude_integrator.sv
rtl/sria_checker.sv
verif/tb.sv
